### sv/plfm_pkg.sv
// ----------------------------------------------------------------------------
// plfm_pkg: shared types and constants of the partitioned LRU frame manager.
// Holds the request and response layouts, the frame table entry, opcodes and
// status codes.
// ----------------------------------------------------------------------------
package plfm_pkg;

  // Default table size and register reset value.
  localparam int NUM_FRAMES_DEF = 32;
  localparam logic [5:0] RT_AREA_RESET = 6'd8;

  // Request opcodes.
  localparam logic [1:0] OP_ACCESS  = 2'd0;
  localparam logic [1:0] OP_PRELOAD = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Response status codes.
  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_LOADED   = 3'd2;
  localparam logic [2:0] ST_REPLACED = 3'd3;
  localparam logic [2:0] ST_NO_FRAME = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         process_id;
    logic signed [15:0] page_number;
    logic               is_real_time;
    logic [7:0]         working_set_size;
  } plfm_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               page_fault;
    logic [4:0]         frame_index;
    logic signed [15:0] victim_page;
    logic [5:0]         frames_released;
  } plfm_rsp_t;

  // One frame table word; the occupied bit lives in flip-flops outside.
  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] page;
    logic [31:0] stamp;
  } plfm_entry_t;

endpackage

### sv/partitioned_local_lru_frame_manager.sv
// ----------------------------------------------------------------------------
// partitioned_local_lru_frame_manager: per-process LRU page frame manager.
// Frame table with a real-time area in the lowest frames and a user area
// above it; access, preload, release and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req) takes one request at a
//   time. A request is accepted when req_valid is high and req_stall is low.
//   The response channel (rsp_valid, rsp_stall, rsp) carries one response per
//   request, held stable while rsp_stall is high.
//   The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
//   real-time area size and is always ready; the user must write it only
//   while idle, since the block itself does not enforce this.
// Table walk:
//   Access, preload and release walk the frame table one frame per cycle
//   through the single read port of the table RAM with one shared stamp
//   comparator, then respond from the decide step; clear and ignored
//   requests skip the walk and go straight to the decide step.
// Reset:
//   All frames become free and the use clock returns to zero at once, since
//   the occupied bits are flip-flops; no clearing pass is needed.
// Stalls:
//   A new request may be accepted while a response waits; its final write
//   is held until the waiting response has been taken.
// ----------------------------------------------------------------------------
module partitioned_local_lru_frame_manager #(
  parameter int NUM_FRAMES = plfm_pkg::NUM_FRAMES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  plfm_pkg::plfm_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output plfm_pkg::plfm_rsp_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);

  import plfm_pkg::*;

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int CW    = (CNT_W > 9) ? CNT_W : 9;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]            state;
  plfm_req_t             cur;
  logic [5:0]            rt_area;
  logic [31:0]           use_clock;
  logic [NUM_FRAMES-1:0] occupied;

  // Scan pointer and read pipeline.
  logic                  issuing;
  logic [IDX_W-1:0]      scan_idx;
  logic                  chk_vld;
  logic [IDX_W-1:0]      chk_idx;

  // Scan results.
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [CW-1:0]         used;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  lru_found;
  logic [IDX_W-1:0]      lru_idx;
  logic [31:0]           lru_stamp;
  logic [15:0]           lru_page;

  // Table RAM ports.
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  plfm_entry_t           wr_entry;
  logic [$bits(plfm_entry_t)-1:0] rd_data;
  plfm_entry_t           rd_entry;

  logic                  accept;
  logic                  hold;
  logic                  owner_match;
  logic                  chk_occ;
  logic                  chk_in_rt;
  logic                  page_neg;
  logic [CW-1:0]         rts;
  logic [CW-1:0]         area;
  logic [CW-1:0]         limit;
  logic                  can_free;
  logic [31:0]           fill_stamp;
  logic [IDX_W-1:0]      fill_idx;
  logic                  do_fill;
  logic [2:0]            miss_status;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign hold      = rsp_valid && rsp_stall;
  assign page_neg  = cur.page_number[15];

  plfm_ram #(
    .WIDTH($bits(plfm_entry_t)),
    .DEPTH(NUM_FRAMES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_en  (issuing),
    .rd_addr(scan_idx),
    .rd_data(rd_data)
  );

  assign rd_entry = plfm_entry_t'(rd_data);

  // Per-frame checks on the word coming out of the RAM.
  assign chk_occ     = occupied[chk_idx];
  assign owner_match = chk_occ && (rd_entry.owner == cur.process_id);
  assign chk_in_rt   = (CW'(chk_idx) < rts);

  // Area size and frame quota of the current process.
  assign rts   = (CW'(rt_area) > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(rt_area);
  assign area  = cur.is_real_time ? rts : (CW'(NUM_FRAMES) - rts);
  always_comb begin
    if (cur.working_set_size == 8'd0) begin
      limit = CW'(1);
    end else if (CW'(cur.working_set_size) < area) begin
      limit = CW'(cur.working_set_size);
    end else begin
      limit = area;
    end
  end

  // Miss handling: free frame under quota, else own LRU frame.
  assign can_free = free_found && (used < limit);
  always_comb begin
    priority if (can_free) begin
      miss_status = ST_LOADED;
      fill_idx    = free_idx;
    end else if (lru_found) begin
      miss_status = ST_REPLACED;
      fill_idx    = lru_idx;
    end else begin
      miss_status = ST_NO_FRAME;
      fill_idx    = '0;
    end
  end

  assign fill_stamp = (cur.opcode == OP_PRELOAD) ? (use_clock + 32'd1) : use_clock;
  assign do_fill    = (state == S_DECIDE) && !hold && !page_neg && !hit_found &&
                      (miss_status != ST_NO_FRAME) &&
                      ((cur.opcode == OP_ACCESS) || (cur.opcode == OP_PRELOAD));

  // Table write: restamp on an access hit, or load a page on a miss.
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = fill_idx;
    wr_entry.owner = cur.process_id;
    wr_entry.page  = cur.page_number;
    wr_entry.stamp = fill_stamp;
    if ((state == S_DECIDE) && !hold && !page_neg) begin
      if (hit_found && (cur.opcode == OP_ACCESS)) begin
        wr_en          = 1'b1;
        wr_addr        = hit_idx;
        wr_entry.stamp = use_clock;
      end else if (do_fill) begin
        wr_en = 1'b1;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rt_area <= RT_AREA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rt_area <= cfg_data;
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
  end

  // Sequencer: accept, scan the table, then decide and respond.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issuing   <= 1'b0;
      chk_vld   <= 1'b0;
      use_clock <= '0;
      occupied  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DECIDE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if ((req.opcode == OP_ACCESS) && !req.page_number[15]) begin
              use_clock <= use_clock + 32'd1;
            end
            if ((req.opcode == OP_CLEAR) ||
                ((req.opcode != OP_RELEASE) && req.page_number[15])) begin
              state <= S_DECIDE;
            end else begin
              state   <= S_SCAN;
              issuing <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          chk_vld <= issuing;
          if (issuing && (scan_idx == LAST_IDX)) begin
            issuing <= 1'b0;
          end
          if (chk_vld && owner_match && (cur.opcode == OP_RELEASE)) begin
            occupied[chk_idx] <= 1'b0;
          end
          if (!issuing && !chk_vld) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!hold) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
            if (cur.opcode == OP_CLEAR) begin
              occupied  <= '0;
              use_clock <= '0;
            end
            if (do_fill) begin
              occupied[fill_idx] <= 1'b1;
              if (cur.opcode == OP_PRELOAD) begin
                use_clock <= fill_stamp;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan pointer and accumulated scan results.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      scan_idx   <= '0;
      chk_idx    <= '0;
      hit_found  <= 1'b0;
      hit_idx    <= '0;
      used       <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
      lru_found  <= 1'b0;
      lru_idx    <= '0;
      lru_stamp  <= '0;
      lru_page   <= '0;
    end else if (state == S_SCAN) begin
      chk_idx <= scan_idx;
      if (issuing && (scan_idx != LAST_IDX)) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (chk_vld) begin
        if (owner_match) begin
          used <= used + CW'(1);
        end
        if (owner_match && (rd_entry.page == cur.page_number) && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= chk_idx;
        end
        if (!chk_occ && (chk_in_rt == cur.is_real_time) && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
        // Shared stamp comparator: signed order, lowest frame wins a tie.
        if (owner_match &&
            (!lru_found || ($signed(rd_entry.stamp) < $signed(lru_stamp)))) begin
          lru_found <= 1'b1;
          lru_idx   <= chk_idx;
          lru_stamp <= rd_entry.stamp;
          lru_page  <= rd_entry.page;
        end
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    logic [CW-1:0] frame_ext;
    if ((state == S_DECIDE) && !hold) begin
      rsp.status          <= ST_IGNORED;
      rsp.page_fault      <= 1'b0;
      rsp.frame_index     <= '0;
      rsp.victim_page     <= '1;
      rsp.frames_released <= '0;
      if (cur.opcode == OP_CLEAR) begin
        rsp.status <= ST_DONE;
      end else if (cur.opcode == OP_RELEASE) begin
        rsp.status          <= ST_DONE;
        rsp.frames_released <= used[5:0];
      end else if (!page_neg) begin
        if (hit_found) begin
          frame_ext       = CW'(hit_idx);
          rsp.status      <= ST_HIT;
          rsp.frame_index <= frame_ext[4:0];
        end else begin
          frame_ext       = CW'(fill_idx);
          rsp.status      <= miss_status;
          rsp.page_fault  <= (cur.opcode == OP_ACCESS);
          rsp.frame_index <= frame_ext[4:0];
          if (miss_status == ST_REPLACED) begin
            rsp.victim_page <= lru_page;
          end
        end
      end
    end
  end

  // A response appears only from the decide step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_DECIDE))
    else $error("response raised outside the decide step");

  // The scan never marks a frame occupied.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> ((occupied & ~$past(occupied)) == '0))
    else $error("frame became occupied during a scan");

  // A fault only comes with a miss outcome.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.page_fault) |->
      ((rsp.status == ST_LOADED) || (rsp.status == ST_REPLACED) ||
       (rsp.status == ST_NO_FRAME)))
    else $error("page fault reported with a non-miss status");

  // A completed clear leaves an empty table and a zero clock.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_DECIDE) && !hold && (cur.opcode == OP_CLEAR)) |=>
      ((occupied == '0) && (use_clock == '0)))
    else $error("clear did not empty the table");

  // A victim page is reported only on replacement.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_REPLACED)) |-> (rsp.victim_page == '1))
    else $error("victim page reported without replacement");

endmodule

### sv/plfm_ram.sv
// ----------------------------------------------------------------------------
// plfm_ram: generic single-write, single-read RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### bench/partitioned_local_lru_frame_manager_tb.sv
// ----------------------------------------------------------------------------
// partitioned_local_lru_frame_manager_tb: self-checking bench for the frame
// manager.
// A scoreboard keeps its own copy of the frame table, the use clock and the
// real-time area size. It works out the response of every accepted request
// and compares each response field by field, in order. The stimulus is a
// short directed run followed by random phases at several area sizes, with
// random idling on both channels, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------

// Scoreboard: predicts each response from its own table copy.
class lru_frame_scoreboard;
  localparam int FRAMES = plfm_pkg::NUM_FRAMES_DEF;

  bit                  occupied [FRAMES];
  logic [7:0]          owner    [FRAMES];
  logic [15:0]         page     [FRAMES];
  logic [31:0]         stamp    [FRAMES];
  logic [31:0]         use_clock;
  logic [5:0]          rt_area;
  plfm_pkg::plfm_rsp_t pending_responses[$];
  int                  errors;

  function new();
    rt_area = plfm_pkg::RT_AREA_RESET;
    errors = 0;
    for (int i = 0; i < FRAMES; i++) free_frame_entry(i);
    use_clock = '0;
  endfunction

  function void free_frame_entry(int i);
    occupied[i] = 1'b0;
    owner[i] = '0;
    page[i] = 16'hFFFF;
    stamp[i] = '0;
  endfunction

  function void set_rt_area(logic [5:0] value);
    rt_area = value;
  endfunction

  function int rt_size();
    return (rt_area > FRAMES) ? FRAMES : int'(rt_area);
  endfunction

  // First free frame of the requester's area, or -1 when its quota is used up or no frame of its area is free.
  function int pick_free_frame(logic [7:0] pid, logic rt, logic [7:0] ws);
    int rts, area, quota, used;
    rts = rt_size();
    area = rt ? rts : FRAMES - rts;
    used = 0;
    if (ws == 0) quota = 1;
    else quota = (int'(ws) < area) ? int'(ws) : area;
    for (int i = 0; i < FRAMES; i++)
      if (occupied[i] && owner[i] == pid) used++;
    if (used >= quota) return -1;
    for (int i = 0; i < FRAMES; i++)
      if (!occupied[i] && ((i < rts) == rt)) return i;
    return -1;
  endfunction

  // Oldest frame of the requester; stamps compare as signed, lowest wins a tie.
  function int pick_lru_frame(logic [7:0] pid);
    int best;
    logic [31:0] oldest;
    best = -1;
    oldest = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (occupied[i] && owner[i] == pid) begin
        if (best < 0 || $signed(stamp[i]) < $signed(oldest)) begin
          best = i;
          oldest = stamp[i];
        end
      end
    end
    return best;
  endfunction

  // Work out the response of an accepted request and queue it.
  function void note_request(plfm_pkg::plfm_req_t r);
    plfm_pkg::plfm_rsp_t e;
    int idx, count;
    bit is_access;
    e.status = plfm_pkg::ST_IGNORED;
    e.page_fault = 1'b0;
    e.frame_index = '0;
    e.victim_page = 16'hFFFF;
    e.frames_released = '0;
    is_access = (r.opcode == plfm_pkg::OP_ACCESS);
    if (r.opcode == plfm_pkg::OP_RELEASE) begin
      count = 0;
      for (int i = 0; i < FRAMES; i++) begin
        if (occupied[i] && owner[i] == r.process_id) begin
          free_frame_entry(i);
          count++;
        end
      end
      e.status = plfm_pkg::ST_DONE;
      e.frames_released = count[5:0];
    end else if (r.opcode == plfm_pkg::OP_CLEAR) begin
      for (int i = 0; i < FRAMES; i++) free_frame_entry(i);
      use_clock = '0;
      e.status = plfm_pkg::ST_DONE;
    end else if (!r.page_number[15]) begin
      if (is_access) use_clock = use_clock + 32'd1;
      idx = -1;
      for (int i = 0; i < FRAMES; i++)
        if (idx < 0 && occupied[i] && owner[i] == r.process_id && page[i] == r.page_number)
          idx = i;
      if (idx >= 0) begin
        // Hit: only an access refreshes the stamp.
        if (is_access) stamp[idx] = use_clock;
        e.status = plfm_pkg::ST_HIT;
        e.frame_index = idx[4:0];
      end else begin
        if (is_access) e.page_fault = 1'b1;
        idx = pick_free_frame(r.process_id, r.is_real_time, r.working_set_size);
        e.status = plfm_pkg::ST_LOADED;
        if (idx < 0) begin
          idx = pick_lru_frame(r.process_id);
          e.status = plfm_pkg::ST_REPLACED;
        end
        if (idx < 0) begin
          e.status = plfm_pkg::ST_NO_FRAME;
        end else begin
          if (e.status == plfm_pkg::ST_REPLACED) e.victim_page = page[idx];
          if (!is_access) use_clock = use_clock + 32'd1;
          occupied[idx] = 1'b1;
          owner[idx] = r.process_id;
          page[idx] = r.page_number;
          stamp[idx] = use_clock;
          e.frame_index = idx[4:0];
        end
      end
    end
    pending_responses = {pending_responses, e};
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 100) $display("ERROR: %s", msg);
  endtask

  // Compare one accepted response with the oldest prediction.
  task check_response(plfm_pkg::plfm_rsp_t got);
    plfm_pkg::plfm_rsp_t e;
    if (pending_responses.size() == 0) begin
      report_mismatch("response with no request waiting");
    end else begin
      e = pending_responses.pop_front();
      if (got.status != e.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, e.status));
      if (got.page_fault != e.page_fault)
        report_mismatch($sformatf("page_fault %0d, expected %0d",
                                  got.page_fault, e.page_fault));
      if (got.frame_index != e.frame_index)
        report_mismatch($sformatf("frame_index %0d, expected %0d",
                                  got.frame_index, e.frame_index));
      if (got.victim_page != e.victim_page)
        report_mismatch($sformatf("victim_page %0d, expected %0d",
                                  got.victim_page, e.victim_page));
      if (got.frames_released != e.frames_released)
        report_mismatch($sformatf("frames_released %0d, expected %0d",
                                  got.frames_released, e.frames_released));
    end
  endtask
endclass

module partitioned_local_lru_frame_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plfm_pkg::*;

  localparam int NUM_FRAMES = NUM_FRAMES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 160;
  localparam int NUM_PROCS = 6;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  plfm_req_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  plfm_rsp_t rsp;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [5:0] cfg_data;

  lru_frame_scoreboard sb;
  bit         tx_idle_on;
  bit         rx_idle_on;
  int         holdoff_seq;
  int         cycle_count;
  logic       proc_rt [NUM_PROCS];
  logic [7:0] proc_ws [NUM_PROCS];

  partitioned_local_lru_frame_manager #(
    .NUM_FRAMES(NUM_FRAMES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Response monitor.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int holdoff_seen, holdoff_left;
    holdoff_seen = 0;
    holdoff_left = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_seq != holdoff_seen) begin
        holdoff_seen = holdoff_seq;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        rsp_stall = 1'b1;
        holdoff_left--;
      end else if (rx_idle_on) begin
        rsp_stall = ($urandom_range(0, 99) < 37);
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  function automatic plfm_req_t mk_req(logic [1:0] op, logic [7:0] pid, logic [15:0] pg,
                                       logic rt, logic [7:0] ws);
    plfm_req_t r;
    r.opcode = op;
    r.process_id = pid;
    r.page_number = pg;
    r.is_real_time = rt;
    r.working_set_size = ws;
    return r;
  endfunction

  // Random request: mostly a few processes on a few pages so that hits,
  // quota limits and evictions happen, with some noise over the full ranges.
  function automatic plfm_req_t random_request();
    plfm_req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 62) r.opcode = OP_ACCESS;
    else if (roll < 84) r.opcode = OP_PRELOAD;
    else if (roll < 94) r.opcode = OP_RELEASE;
    else if (roll < 96) r.opcode = OP_CLEAR;
    else r.opcode = 2'($urandom_range(0, 3));
    r.process_id = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, NUM_PROCS - 1))
                                               : 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 85) r.page_number = 16'($urandom_range(0, 11));
    else if (roll < 92) r.page_number = 16'($urandom_range(0, 32767));
    else r.page_number = 16'($urandom_range(0, 65535));
    if (r.process_id < NUM_PROCS && $urandom_range(0, 99) < 85) begin
      r.is_real_time = proc_rt[r.process_id];
      r.working_set_size = proc_ws[r.process_id];
    end else begin
      r.is_real_time = 1'($urandom_range(0, 1));
      r.working_set_size = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  // Offer one request, after an optional random gap, until it is accepted.
  task automatic send_request(input plfm_req_t r);
    int gap;
    gap = 0;
    if (tx_idle_on) begin
      while ($urandom_range(0, 99) < 37) gap++;
      if ($urandom_range(0, 19) == 0) gap += $urandom_range(1, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic stop_requests();
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic wait_for_responses();
    while (sb.pending_responses.size() != 0) @(posedge clk);
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic write_rt_area(input logic [5:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_rt_area(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Main sequence.
  initial begin
    plfm_req_t  r;
    plfm_req_t  directed[$];
    logic [5:0] area_list[8];
    int         counted;
    bit         paused;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    holdoff_seq = 0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset area size of eight frames.
    directed = {directed, mk_req(OP_ACCESS,  8'd0,   16'd0,     1'b0, 8'd0)};   // free load
    directed = {directed, mk_req(OP_ACCESS,  8'd0,   16'd1,     1'b0, 8'd0)};   // quota of one
    directed = {directed, mk_req(OP_ACCESS,  8'd0,   16'd1,     1'b0, 8'd0)};   // hit
    directed = {directed, mk_req(OP_PRELOAD, 8'd0,   16'd1,     1'b0, 8'd0)};   // preload hit
    directed = {directed, mk_req(OP_PRELOAD, 8'd0,   16'd2,     1'b0, 8'd0)};   // preload evict
    directed = {directed, mk_req(OP_ACCESS,  8'd255, 16'd32767, 1'b1, 8'd255)};
    directed = {directed, mk_req(OP_ACCESS,  8'd3,   16'hFFFF,  1'b1, 8'd255)}; // no page
    directed = {directed, mk_req(OP_ACCESS,  8'd3,   16'h8000,  1'b0, 8'd1)};
    directed = {directed, mk_req(OP_PRELOAD, 8'd3,   16'hFFFF,  1'b0, 8'd1)};
    for (int p = 10; p < 17; p++)
      directed = {directed, mk_req(OP_ACCESS, 8'd1, 16'(p), 1'b1, 8'd255)}; // fill RT area
    directed = {directed, mk_req(OP_ACCESS,  8'd2,   16'd5,     1'b1, 8'd4)};   // no frame
    directed = {directed, mk_req(OP_PRELOAD, 8'd2,   16'd6,     1'b1, 8'd4)};
    directed = {directed, mk_req(OP_RELEASE, 8'd1,   16'hFFFF,  1'b1, 8'd0)};
    directed = {directed, mk_req(OP_RELEASE, 8'd9,   16'd0,     1'b0, 8'd0)};   // owns nothing
    directed = {directed, mk_req(OP_CLEAR,   8'd0,   16'd0,     1'b0, 8'd0)};
    foreach (directed[k]) send_request(directed[k]);
    stop_requests();
    wait_for_responses();

    // Random phases, one area size each, extremes first.
    area_list = '{6'd0, 6'd32, 6'd63, 6'd1, 6'd31, 6'd8,
                  6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))};
    for (int ph = 0; ph < 8; ph++) begin
      write_rt_area(area_list[ph]);
      for (int p = 0; p < NUM_PROCS; p++) begin
        proc_rt[p] = 1'($urandom_range(0, 1));
        proc_ws[p] = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
      end
      tx_idle_on = (ph != 2);
      rx_idle_on = (ph != 2);
      // The receiver holds off while requests keep coming, filling the block.
      if (ph == 1) holdoff_seq++;
      counted = 0;
      paused = 1'b0;
      while (counted < PHASE_ITEMS) begin
        r = random_request();
        if (!((r.opcode == OP_ACCESS || r.opcode == OP_PRELOAD) && r.page_number[15]))
          counted++;
        send_request(r);
        // In phase four the sender pauses once, halfway, until every response has come back.
        if (ph == 4 && !paused && counted >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          stop_requests();
          wait_for_responses();
        end
      end
      stop_requests();
      wait_for_responses();
    end

    repeat (NUM_FRAMES + 8) @(posedge clk);
    if (sb.pending_responses.size() != 0)
      sb.report_mismatch($sformatf("%0d responses never arrived",
                                   sb.pending_responses.size()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/plfm_pkg.sv
sv/plfm_ram.sv
sv/partitioned_local_lru_frame_manager.sv
bench/partitioned_local_lru_frame_manager_tb.sv
